// ===== hdl/cpsat_pkg.sv =====
// shared types and codes for the convex polygon separating-axis core
package cpsat_pkg;

  localparam int CoordW = 20;
  localparam int SumW   = CoordW + 1;
  localparam int ProdW  = 2 * SumW;
  localparam int ProjW  = ProdW + 1;

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_TEST   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } vert_t;

  typedef struct packed {
    logic valid;
    logic is_b;
    logic first;
  } proj_tag_t;

endpackage

// ===== hdl/cpsat_if.sv =====
// request and response channel interfaces
interface cpsat_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             opcode;
  logic                                   restart;
  logic signed [cpsat_pkg::CoordW-1:0]    vert_x;
  logic signed [cpsat_pkg::CoordW-1:0]    vert_y;
  logic signed [cpsat_pkg::CoordW-1:0]    pos_a_x;
  logic signed [cpsat_pkg::CoordW-1:0]    pos_a_y;
  logic signed [cpsat_pkg::CoordW-1:0]    pos_b_x;
  logic signed [cpsat_pkg::CoordW-1:0]    pos_b_y;
  modport source (output valid, opcode, restart, vert_x, vert_y, pos_a_x, pos_a_y,
                  pos_b_x, pos_b_y, input ready);
  modport sink (input valid, opcode, restart, vert_x, vert_y, pos_a_x, pos_a_y,
                pos_b_x, pos_b_y, output ready);
endinterface

interface cpsat_rsp_if;
  logic valid;
  logic ready;
  logic is_test_result;
  logic collide;
  logic store_full;
  logic empty_polygon;
  modport source (output valid, is_test_result, collide, store_full, empty_polygon,
                  input ready);
  modport sink (input valid, is_test_result, collide, store_full, empty_polygon,
                output ready);
endinterface

// ===== hdl/cpsat_cell.sv =====
// one vertex cell of a rotating vertex ring
module cpsat_cell (
  input  logic               clk,
  input  logic               load_en,
  input  cpsat_pkg::vert_t   load_vert,
  input  logic               shift_en,
  input  cpsat_pkg::vert_t   shift_vert,
  output cpsat_pkg::vert_t   vert
);

  always_ff @(posedge clk) begin
    if (load_en) begin
      vert <= load_vert;
    end else if (shift_en) begin
      vert <= shift_vert;
    end
  end

endmodule

// ===== hdl/cpsat_ring.sv =====
// ring of vertex cells; rotation moves the next vertex to the head
module cpsat_ring #(
  parameter int N  = 32,
  parameter int CW = $clog2(N + 1),
  parameter int IW = $clog2(N)
) (
  input  logic              clk,
  input  logic [CW-1:0]     count,
  input  logic              load_en,
  input  logic [IW-1:0]     load_idx,
  input  cpsat_pkg::vert_t  load_vert,
  input  logic              shift_en,
  output cpsat_pkg::vert_t  head,
  output cpsat_pkg::vert_t  second
);

  cpsat_pkg::vert_t verts [N];

  for (genvar k = 0; k < N; k++) begin : g_cell
    cpsat_pkg::vert_t shift_in;
    if (k == N - 1) begin : g_last
      assign shift_in = verts[0];
    end else begin : g_mid
      // the last occupied cell takes the head, so the head wraps around
      assign shift_in = (count == CW'(k + 1)) ? verts[0] : verts[k+1];
    end
    cpsat_cell u_cell (
      .clk        (clk),
      .load_en    (load_en && (load_idx == IW'(k))),
      .load_vert  (load_vert),
      .shift_en   (shift_en),
      .shift_vert (shift_in),
      .vert       (verts[k])
    );
  end

  assign head   = verts[0];
  assign second = verts[1];

endmodule

// ===== hdl/cpsat_proj.sv =====
// projection pipeline with running min and max for both polygons
module cpsat_proj (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cpsat_pkg::proj_tag_t                  tag,
  input  cpsat_pkg::vert_t                      vert,
  input  cpsat_pkg::vert_t                      pos,
  input  logic signed [cpsat_pkg::SumW-1:0]     nx,
  input  logic signed [cpsat_pkg::SumW-1:0]     ny,
  output logic signed [cpsat_pkg::ProjW-1:0]    a_min,
  output logic signed [cpsat_pkg::ProjW-1:0]    a_max,
  output logic signed [cpsat_pkg::ProjW-1:0]    b_min,
  output logic signed [cpsat_pkg::ProjW-1:0]    b_max
);

  cpsat_pkg::proj_tag_t                 tag0, tag1;
  logic signed [cpsat_pkg::SumW-1:0]    sx, sy;
  logic signed [cpsat_pkg::ProdW-1:0]   px, py;
  logic signed [cpsat_pkg::ProjW-1:0]   d;

  assign d = cpsat_pkg::ProjW'(px) + cpsat_pkg::ProjW'(py);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag0 <= '0;
      tag1 <= '0;
    end else begin
      tag0 <= tag;
      tag1 <= tag0;
    end
    sx <= cpsat_pkg::SumW'(pos.x) + cpsat_pkg::SumW'(vert.x);
    sy <= cpsat_pkg::SumW'(pos.y) + cpsat_pkg::SumW'(vert.y);
    px <= nx * sx;
    py <= ny * sy;
    if (tag1.valid) begin
      if (tag1.is_b) begin
        if (tag1.first || d < b_min) b_min <= d;
        if (tag1.first || d > b_max) b_max <= d;
      end else begin
        if (tag1.first || d < a_min) a_min <= d;
        if (tag1.first || d > a_max) a_max <= d;
      end
    end
  end

endmodule

// ===== hdl/convex_polygon_sat_overlap_core.sv =====
// separating-axis overlap core for two convex polygons
//
//  port  dir   carries
//  req   sink  opcode, restart, vertex, positions of a and b
//  rsp   src   is_test_result, collide, store_full, empty_polygon
//
// a load answers at once; a test walks each edge of polygon a in turn through the one
// projection pipeline fed from the head of each vertex ring, projecting both polygons.
// a test with an empty polygon answers at once, with empty_polygon set.
// rst is synchronous and empties both vertex lists.
// a response waiting on rsp.ready holds req.ready low until it is taken.
module convex_polygon_sat_overlap_core #(
  parameter int MAX_VERTICES = 32
) (
  input  logic          clk,
  input  logic          rst,
  cpsat_req_if.sink     req,
  cpsat_rsp_if.source   rsp
);

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int IW = $clog2(MAX_VERTICES);

  typedef enum logic [2:0] {S_IDLE, S_EDGE, S_PA, S_PB, S_DRAIN, S_CMP, S_DONE} state_t;

  state_t                               state;
  logic [CW-1:0]                        count_a, count_b, cnt, edge_cnt;
  cpsat_pkg::vert_t                     pos_a, pos_b;
  logic signed [cpsat_pkg::SumW-1:0]    nx, ny;
  logic                                 collide_acc;
  cpsat_pkg::vert_t                     head_a, second_a, head_b, second_b, edge_b;
  cpsat_pkg::vert_t                     load_vert;
  logic signed [cpsat_pkg::ProjW-1:0]   a_min, a_max, b_min, b_max;
  cpsat_pkg::proj_tag_t                 tag;
  cpsat_pkg::vert_t                     issue_vert, issue_pos;
  logic                                 acc, rsp_free, rsp_set, poly_empty;
  logic                                 ld_a, ld_b, full_a, full_b;
  logic [IW-1:0]                        idx_a, idx_b;
  logic                                 shift_a, shift_b;

  assign rsp_free  = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && rsp_free;
  assign acc       = req.valid && req.ready;
  assign load_vert = '{x: req.vert_x, y: req.vert_y};

  assign full_a = !req.restart && (count_a == CW'(MAX_VERTICES));
  assign full_b = !req.restart && (count_b == CW'(MAX_VERTICES));
  assign idx_a  = req.restart ? '0 : count_a[IW-1:0];
  assign idx_b  = req.restart ? '0 : count_b[IW-1:0];
  assign ld_a   = acc && (req.opcode == cpsat_pkg::OP_LOAD_A) && !full_a;
  assign ld_b   = acc && (req.opcode == cpsat_pkg::OP_LOAD_B) && !full_b;

  assign poly_empty = (count_a == '0) || (count_b == '0);
  // every word answers at once except a test that walks the edges
  assign rsp_set = (acc && !((req.opcode == cpsat_pkg::OP_TEST) && !poly_empty))
                || ((state == S_DONE) && rsp_free);

  assign shift_a = (state == S_PA) || (state == S_CMP);
  assign shift_b = (state == S_PB);

  // a single-vertex polygon closes its edge on itself
  assign edge_b = (count_a == CW'(1)) ? head_a : second_a;

  always_comb begin
    tag        = '0;
    issue_vert = head_a;
    issue_pos  = pos_a;
    if (state == S_PA) begin
      tag = '{valid: 1'b1, is_b: 1'b0, first: (cnt == '0)};
    end else if (state == S_PB) begin
      tag        = '{valid: 1'b1, is_b: 1'b1, first: (cnt == '0)};
      issue_vert = head_b;
      issue_pos  = pos_b;
    end
  end

  cpsat_ring #(.N(MAX_VERTICES)) u_ring_a (
    .clk (clk), .count (count_a), .load_en (ld_a), .load_idx (idx_a),
    .load_vert (load_vert), .shift_en (shift_a), .head (head_a), .second (second_a)
  );

  cpsat_ring #(.N(MAX_VERTICES)) u_ring_b (
    .clk (clk), .count (count_b), .load_en (ld_b), .load_idx (idx_b),
    .load_vert (load_vert), .shift_en (shift_b), .head (head_b), .second (second_b)
  );

  cpsat_proj u_proj (
    .clk (clk), .rst (rst), .tag (tag), .vert (issue_vert), .pos (issue_pos),
    .nx (nx), .ny (ny), .a_min (a_min), .a_max (a_max), .b_min (b_min), .b_max (b_max)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count_a   <= '0;
      count_b   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp_set) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            unique case (req.opcode)
              cpsat_pkg::OP_LOAD_A: begin
                rsp.is_test_result <= 1'b0;
                rsp.collide        <= 1'b0;
                rsp.store_full     <= full_a;
                rsp.empty_polygon  <= 1'b0;
                if (!full_a) count_a <= CW'(idx_a) + CW'(1);
              end
              cpsat_pkg::OP_LOAD_B: begin
                rsp.is_test_result <= 1'b0;
                rsp.collide        <= 1'b0;
                rsp.store_full     <= full_b;
                rsp.empty_polygon  <= 1'b0;
                if (!full_b) count_b <= CW'(idx_b) + CW'(1);
              end
              cpsat_pkg::OP_TEST: begin
                if (poly_empty) begin
                  rsp.is_test_result <= 1'b1;
                  rsp.collide        <= 1'b0;
                  rsp.store_full     <= 1'b0;
                  rsp.empty_polygon  <= 1'b1;
                end else begin
                  pos_a       <= '{x: req.pos_a_x, y: req.pos_a_y};
                  pos_b       <= '{x: req.pos_b_x, y: req.pos_b_y};
                  collide_acc <= 1'b1;
                  edge_cnt    <= '0;
                  state       <= S_EDGE;
                end
              end
              default: begin
                rsp.is_test_result <= 1'b0;
                rsp.collide        <= 1'b0;
                rsp.store_full     <= 1'b0;
                rsp.empty_polygon  <= 1'b0;
              end
            endcase
          end
        end
        S_EDGE: begin
          nx    <= cpsat_pkg::SumW'(edge_b.y) - cpsat_pkg::SumW'(head_a.y);
          ny    <= cpsat_pkg::SumW'(head_a.x) - cpsat_pkg::SumW'(edge_b.x);
          cnt   <= '0;
          state <= S_PA;
        end
        S_PA: begin
          if (cnt == count_a - CW'(1)) begin
            cnt   <= '0;
            state <= S_PB;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_PB: begin
          if (cnt == count_b - CW'(1)) begin
            cnt   <= '0;
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_DRAIN: begin
          // two pipeline stages before the extremes settle
          cnt <= cnt + CW'(1);
          if (cnt == CW'(1)) state <= S_CMP;
        end
        S_CMP: begin
          if (!(b_max > a_min && b_min < a_max)) collide_acc <= 1'b0;
          if (edge_cnt == count_a - CW'(1)) begin
            state <= S_DONE;
          end else begin
            edge_cnt <= edge_cnt + CW'(1);
            state    <= S_EDGE;
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp.is_test_result <= 1'b1;
            rsp.collide        <= collide_acc;
            rsp.store_full     <= 1'b0;
            rsp.empty_polygon  <= 1'b0;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
